>>> hdl/smd_pkg.sv
// shared constants and helper functions for the sha-256 message digest
// round constants, initial hash values, padding constants and the sigma functions
// no dependencies
`default_nettype none

package smd_pkg;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

>>> hdl/sha256_message_digest.sv
// sha-256 message digest, one message byte per input transaction
// uses smd_pkg for round constants, initial values and sigma functions
//
// input channel: in_valid/in_stall with data_byte, byte_valid and last.
// a transaction with byte_valid adds data_byte to the message; last ends the
// message (with or without a byte). a transaction carrying neither is taken
// and ignored. in_stall is low only while the block is idle.
// a byte that does not complete a 64-byte block is taken without a stall. a byte that
// completes a block stalls the input for the compression: 64 rounds of the shared
// round unit, one per cycle, then an update state that folds into the chaining words.
// after last, padding bytes go through the same byte path at one per cycle
// (64 minus bytes held), then the compression, and a second padded block with
// its own compression when fewer than 9 byte positions were free.
// output channel: out_valid/out_stall with digest_word, word_index and
// last_word. eight transactions, word 0 first; out_stall holds the current
// word. after the eighth word the chaining words, byte count and bit length
// return to their initial values and the input opens again.
// reset (rst, synchronous) starts a fresh empty message.
`default_nettype none

module sha256_message_digest (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD    = 3'd1;
  localparam logic [2:0] ST_ROUND  = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]   state;
  logic [31:0]  hash [8];
  logic [31:0]  v [8];
  logic [511:0] window;
  logic [5:0]   fill;
  logic [63:0]  message_bits;
  logic [5:0]   round;
  logic [2:0]   out_idx;
  logic         finish;
  logic         padding;
  logic         mark_sent;
  logic         len_ok;

  logic [7:0]   pad_byte;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2, choose, major;

  assign in_stall    = (state != ST_IDLE);
  assign out_valid   = (state == ST_EMIT);
  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  always_comb begin
    if (!mark_sent) begin
      pad_byte = smd_pkg::PAD_MARK;
    end else if (len_ok && fill >= smd_pkg::LEN_POS) begin
      pad_byte = message_bits[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign w0    = window[511:480];
  assign w1    = window[479:448];
  assign w9    = window[223:192];
  assign w14   = window[63:32];
  assign w_new = smd_pkg::small_sigma1(w14) + w9 + smd_pkg::small_sigma0(w1) + w0;

  assign choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1     = v[7] + smd_pkg::big_sigma1(v[4]) + choose + smd_pkg::ROUND_CONST[round] + w0;
  assign t2     = smd_pkg::big_sigma0(v[0]) + major;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      hash         <= smd_pkg::INIT_HASH;
      fill         <= '0;
      message_bits <= '0;
      round        <= '0;
      out_idx      <= '0;
      finish       <= 1'b0;
      padding      <= 1'b0;
      mark_sent    <= 1'b0;
      len_ok       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (byte_valid) begin
              window       <= {window[503:0], data_byte};
              fill         <= fill + 6'd1;
              message_bits <= message_bits + 64'd8;
            end
            if (byte_valid && fill == 6'd63) begin
              state  <= ST_ROUND;
              v      <= hash;
              round  <= '0;
              finish <= last;
            end else if (last) begin
              state     <= ST_PAD;
              padding   <= 1'b1;
              mark_sent <= 1'b0;
              len_ok    <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          window    <= {window[503:0], pad_byte};
          fill      <= fill + 6'd1;
          mark_sent <= 1'b1;
          if (!mark_sent) begin
            len_ok <= (fill < smd_pkg::LEN_POS);
          end
          if (fill == 6'd63) begin
            state <= ST_ROUND;
            v     <= hash;
            round <= '0;
          end
        end
        ST_ROUND: begin
          v[7]   <= v[6];
          v[6]   <= v[5];
          v[5]   <= v[4];
          v[4]   <= v[3] + t1;
          v[3]   <= v[2];
          v[2]   <= v[1];
          v[1]   <= v[0];
          v[0]   <= t1 + t2;
          window <= {window[479:0], w_new};
          round  <= round + 6'd1;
          if (round == 6'd63) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
          end
          if (padding) begin
            if (len_ok) begin
              state   <= ST_EMIT;
              out_idx <= '0;
            end else begin
              state  <= ST_PAD;
              len_ok <= 1'b1;
            end
          end else if (finish) begin
            state     <= ST_PAD;
            finish    <= 1'b0;
            padding   <= 1'b1;
            mark_sent <= 1'b0;
            len_ok    <= 1'b0;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state        <= ST_IDLE;
              hash         <= smd_pkg::INIT_HASH;
              fill         <= '0;
              message_bits <= '0;
              padding      <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
